[hdl/assert_macros.svh]
// Assertion macros for the checker file ars_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[hdl/ars_pkg.sv]
// Package for the AC RMS block: widths, types, register indexes, reset values, states.
// No dependencies.
package ars_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MAX_WINDOW  = 256;
    localparam int CNT_W       = 9;
    localparam int FRAC_W      = 16;
    localparam int OFF_W       = SAMPLE_BITS + FRAC_W;
    localparam int SUM_W       = 34;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int ACC_W       = 46;
    localparam int QUO_W       = SUM_W + FRAC_W;
    localparam int ALU_W       = 52;
    localparam int REM_W       = CNT_W;
    localparam int VOLT_W      = 28;
    localparam int VOLT_LSB    = 8;
    localparam int MPL_W       = 16;
    localparam int STEP_W      = 6;
    localparam int ROOT_IDX_W  = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = VOLT_W + SAMPLE_BITS;

    typedef logic [ALU_W-1:0]       alu_t;
    typedef logic [ACC_W-1:0]       acc_t;
    typedef logic [OFF_W-1:0]       off_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [QUO_W-1:0]       quo_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [REM_W-1:0]       rem_t;
    typedef logic [STEP_W-1:0]      step_t;
    typedef logic [MPL_W-1:0]       mpl_t;
    typedef logic [SAMPLE_BITS-1:0] smp_t;
    typedef logic [VOLT_W-1:0]      volt_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

    localparam cfg_idx_t REG_WINDOW = 2'd0;
    localparam cfg_idx_t REG_ALPHA  = 2'd1;
    localparam cfg_idx_t REG_GAIN   = 2'd2;

    localparam cnt_t WINDOW_RST = 9'd40;
    localparam mpl_t ALPHA_RST  = 16'd328;
    localparam mpl_t GAIN_RST   = 16'd32256;
    localparam off_t OFF_RST    = 28'h800_0000;

    localparam cnt_t WIN_MIN = 9'd1;
    localparam cnt_t WIN_MAX = 9'd256;
    localparam cnt_t CNT_ONE = 9'd1;

    localparam step_t MUL_LAST  = 6'd15;
    localparam step_t DIV_LAST  = 6'd49;
    localparam step_t SQRT_LAST = 6'd24;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIFF = 9'b000000010,
        ST_MUL  = 9'b000000100,
        ST_OFFS = 9'b000001000,
        ST_SQD  = 9'b000010000,
        ST_SUMA = 9'b000100000,
        ST_DIV  = 9'b001000000,
        ST_SQRT = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        MUL_OFFSET,
        MUL_SQUARE,
        MUL_GAIN
    } mul_op_t;

endpackage

[hdl/ac_rms_with_offset_tracking.sv]
// AC RMS measurement with DC offset tracking: sequencer around one shared 52-bit adder.
// Depends on ars_pkg.
//
// Usage:
//   Input stream (s_axis_*): one 12-bit ADC sample per transfer in tdata[11:0].
//   Output stream (m_axis_*): one result per window, tdata[27:0] voltage_q8,
//   tdata[39:28] offset_level.
//   Config channel (cfg_*): index 0 window_samples, 1 alpha_q16, 2 gain_q8;
//   always ready, write only while the block is idle.
//   A sample transfer is followed by busy cycles: two 16-step shift-add
//   multiplies (offset update, square) on the shared adder plus 4 single
//   steps, so no new sample is taken until the last one is done. The last
//   sample of a window adds 50 restoring divide steps, 25 square-root
//   steps, a 16-step gain multiply and 1 output step before its result
//   appears; the output step waits while an earlier result is pending.
//   s_axis_tready is high only while the sequencer is idle.
//   A finished result waits in the output register; new samples are taken
//   meanwhile, and only the next window end waits for m_axis_tready.
//   Reset (rst_n low, async) restores the register defaults, offset 2048.0,
//   clears the sum, the count and any pending result.
module ac_rms_with_offset_tracking
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ars_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [11:0] sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ars_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [27:0] voltage_q8, [39:28] offset_level
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ars_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ars_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ars_pkg::state_t  state_reg, state_next;
    ars_pkg::mul_op_t mul_op_reg, mul_op_next;
    ars_pkg::cnt_t    win_reg, win_next;
    ars_pkg::mpl_t    alpha_reg, alpha_next;
    ars_pkg::mpl_t    gain_reg, gain_next;
    ars_pkg::smp_t    smp_reg, smp_next;
    ars_pkg::off_t    off_reg, off_next;
    ars_pkg::sum_t    sum_reg, sum_next;
    ars_pkg::cnt_t    cnt_reg, cnt_next;
    ars_pkg::cnt_t    div_n_reg, div_n_next;
    ars_pkg::rem_t    rem_reg, rem_next;
    ars_pkg::quo_t    q_reg, q_next;
    ars_pkg::quo_t    root_reg, root_next;
    ars_pkg::acc_t    acc_reg, acc_next;
    ars_pkg::acc_t    mcand_reg, mcand_next;
    ars_pkg::mpl_t    mplier_reg, mplier_next;
    ars_pkg::step_t   step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    ars_pkg::volt_t   out_volt_reg, out_volt_next;
    ars_pkg::smp_t    out_level_reg, out_level_next;

    ars_pkg::alu_t    alu_a, alu_b, alu_res;
    logic             alu_sub, alu_neg;
    ars_pkg::smp_t    level;
    logic             smp_ge;
    ars_pkg::cnt_t    win_eff, cnt_inc;
    ars_pkg::sum_t    sum_sat;
    ars_pkg::quo_t    bitv, root_upd;
    logic [ars_pkg::REM_W:0] div_t;

    assign level    = off_reg[ars_pkg::OFF_W-1:ars_pkg::FRAC_W];
    assign smp_ge   = (smp_reg >= level);
    assign div_t    = {rem_reg, q_reg[ars_pkg::QUO_W-1]};
    assign bitv     = ars_pkg::quo_t'(1) << {step_reg[ars_pkg::ROOT_IDX_W-1:0], 1'b0};
    assign cnt_inc  = cnt_reg + ars_pkg::CNT_ONE;

    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = ars_pkg::WIN_MIN;
        end
        else if (win_reg > ars_pkg::WIN_MAX)
        begin
            win_eff = ars_pkg::WIN_MAX;
        end
        else
        begin
            win_eff = win_reg;
        end
    end

    // shared adder operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ars_pkg::ST_DIFF:
            begin
                alu_a   = ars_pkg::alu_t'({smp_reg, {ars_pkg::FRAC_W{1'b0}}});
                alu_b   = ars_pkg::alu_t'(off_reg);
                alu_sub = 1'b1;
            end
            ars_pkg::ST_MUL:
            begin
                alu_a = {{(ars_pkg::ALU_W-ars_pkg::ACC_W){acc_reg[ars_pkg::ACC_W-1]}}, acc_reg};
                alu_b = {{(ars_pkg::ALU_W-ars_pkg::ACC_W){mcand_reg[ars_pkg::ACC_W-1]}},
                         mcand_reg};
            end
            ars_pkg::ST_OFFS:
            begin
                alu_a = ars_pkg::alu_t'(off_reg);
                alu_b = {{(ars_pkg::ALU_W-ars_pkg::ACC_W+ars_pkg::FRAC_W)
                          {acc_reg[ars_pkg::ACC_W-1]}},
                         acc_reg[ars_pkg::ACC_W-1:ars_pkg::FRAC_W]};
            end
            ars_pkg::ST_SQD:
            begin
                alu_a   = ars_pkg::alu_t'(smp_ge ? smp_reg : level);
                alu_b   = ars_pkg::alu_t'(smp_ge ? level : smp_reg);
                alu_sub = 1'b1;
            end
            ars_pkg::ST_SUMA:
            begin
                alu_a = ars_pkg::alu_t'(sum_reg);
                alu_b = ars_pkg::alu_t'(acc_reg[ars_pkg::SQ_W-1:0]);
            end
            ars_pkg::ST_DIV:
            begin
                alu_a   = ars_pkg::alu_t'(div_t);
                alu_b   = ars_pkg::alu_t'(div_n_reg);
                alu_sub = 1'b1;
            end
            ars_pkg::ST_SQRT:
            begin
                alu_a   = ars_pkg::alu_t'(q_reg);
                alu_b   = ars_pkg::alu_t'(root_reg | bitv);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ars_pkg::alu_t'(alu_sub);
    assign alu_neg = alu_res[ars_pkg::ALU_W-1];

    assign sum_sat  = alu_res[ars_pkg::SUM_W] ? '1 : alu_res[ars_pkg::SUM_W-1:0];
    assign root_upd = alu_neg ? (root_reg >> 1) : ((root_reg >> 1) | bitv);

    always_comb
    begin
        state_next     = state_reg;
        mul_op_next    = mul_op_reg;
        win_next       = win_reg;
        alpha_next     = alpha_reg;
        gain_next      = gain_reg;
        smp_next       = smp_reg;
        off_next       = off_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        div_n_next     = div_n_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        root_next      = root_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_volt_next  = out_volt_reg;
        out_level_next = out_level_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                ars_pkg::REG_WINDOW: win_next   = cfg_data[ars_pkg::CNT_W-1:0];
                ars_pkg::REG_ALPHA:  alpha_next = cfg_data;
                ars_pkg::REG_GAIN:   gain_next  = cfg_data;
                default:             win_next   = win_reg;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ars_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    smp_next   = s_axis_tdata[ars_pkg::SAMPLE_BITS-1:0];
                    state_next = ars_pkg::ST_DIFF;
                end
            end
            ars_pkg::ST_DIFF:
            begin
                mcand_next  = alu_res[ars_pkg::ACC_W-1:0];
                mplier_next = alpha_reg;
                acc_next    = '0;
                step_next   = ars_pkg::MUL_LAST;
                mul_op_next = ars_pkg::MUL_OFFSET;
                state_next  = ars_pkg::ST_MUL;
            end
            ars_pkg::ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_res[ars_pkg::ACC_W-1:0];
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - ars_pkg::step_t'(1);
                if (step_reg == '0)
                begin
                    case (mul_op_reg)
                        ars_pkg::MUL_OFFSET: state_next = ars_pkg::ST_OFFS;
                        ars_pkg::MUL_SQUARE: state_next = ars_pkg::ST_SUMA;
                        ars_pkg::MUL_GAIN:   state_next = ars_pkg::ST_FIN;
                        default:             state_next = ars_pkg::ST_IDLE;
                    endcase
                end
            end
            ars_pkg::ST_OFFS:
            begin
                off_next   = alu_res[ars_pkg::OFF_W-1:0];
                state_next = ars_pkg::ST_SQD;
            end
            ars_pkg::ST_SQD:
            begin
                mcand_next  = alu_res[ars_pkg::ACC_W-1:0];
                mplier_next = alu_res[ars_pkg::MPL_W-1:0];
                acc_next    = '0;
                step_next   = ars_pkg::MUL_LAST;
                mul_op_next = ars_pkg::MUL_SQUARE;
                state_next  = ars_pkg::ST_MUL;
            end
            ars_pkg::ST_SUMA:
            begin
                if (cnt_inc >= win_eff)
                begin
                    q_next     = {sum_sat, {ars_pkg::FRAC_W{1'b0}}};
                    div_n_next = cnt_inc;
                    rem_next   = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    step_next  = ars_pkg::DIV_LAST;
                    state_next = ars_pkg::ST_DIV;
                end
                else
                begin
                    sum_next   = sum_sat;
                    cnt_next   = cnt_inc;
                    state_next = ars_pkg::ST_IDLE;
                end
            end
            ars_pkg::ST_DIV:
            begin
                rem_next  = alu_neg ? div_t[ars_pkg::REM_W-1:0] : alu_res[ars_pkg::REM_W-1:0];
                q_next    = {q_reg[ars_pkg::QUO_W-2:0], ~alu_neg};
                step_next = step_reg - ars_pkg::step_t'(1);
                if (step_reg == '0)
                begin
                    root_next  = '0;
                    step_next  = ars_pkg::SQRT_LAST;
                    state_next = ars_pkg::ST_SQRT;
                end
            end
            ars_pkg::ST_SQRT:
            begin
                if (!alu_neg)
                begin
                    q_next = alu_res[ars_pkg::QUO_W-1:0];
                end
                root_next = root_upd;
                step_next = step_reg - ars_pkg::step_t'(1);
                if (step_reg == '0)
                begin
                    mcand_next  = ars_pkg::acc_t'(root_upd);
                    mplier_next = gain_reg;
                    acc_next    = '0;
                    step_next   = ars_pkg::MUL_LAST;
                    mul_op_next = ars_pkg::MUL_GAIN;
                    state_next  = ars_pkg::ST_MUL;
                end
            end
            ars_pkg::ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (|acc_reg[ars_pkg::ACC_W-1:ars_pkg::VOLT_LSB+ars_pkg::VOLT_W])
                    begin
                        out_volt_next = '1;
                    end
                    else
                    begin
                        out_volt_next = acc_reg[ars_pkg::VOLT_LSB +: ars_pkg::VOLT_W];
                    end
                    out_level_next = level;
                    out_valid_next = 1'b1;
                    state_next     = ars_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ars_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ars_pkg::ST_IDLE;
            mul_op_reg    <= ars_pkg::MUL_OFFSET;
            win_reg       <= ars_pkg::WINDOW_RST;
            alpha_reg     <= ars_pkg::ALPHA_RST;
            gain_reg      <= ars_pkg::GAIN_RST;
            smp_reg       <= '0;
            off_reg       <= ars_pkg::OFF_RST;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            div_n_reg     <= ars_pkg::WIN_MIN;
            rem_reg       <= '0;
            q_reg         <= '0;
            root_reg      <= '0;
            acc_reg       <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_volt_reg  <= '0;
            out_level_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_op_reg    <= mul_op_next;
            win_reg       <= win_next;
            alpha_reg     <= alpha_next;
            gain_reg      <= gain_next;
            smp_reg       <= smp_next;
            off_reg       <= off_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            div_n_reg     <= div_n_next;
            rem_reg       <= rem_next;
            q_reg         <= q_next;
            root_reg      <= root_next;
            acc_reg       <= acc_next;
            mcand_reg     <= mcand_next;
            mplier_reg    <= mplier_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            out_volt_reg  <= out_volt_next;
            out_level_reg <= out_level_next;
        end
    end

    assign s_axis_tready = (state_reg == ars_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_level_reg, out_volt_reg};
    assign cfg_ready     = 1'b1;

endmodule

[hdl/ars_checker.sv]
// Port-level checker for ac_rms_with_offset_tracking, attached by bind.
// Depends on ars_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ars_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [ars_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ars_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [ars_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [ars_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // sequencer is busy right after a sample transfer
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // after a result transfer, valid stays high only if a new result was just posted
    `ASSERT_NEXT(a_one_result, clk, rst_n, m_axis_tvalid && m_axis_tready,
                 !m_axis_tvalid || s_axis_tready)

    // a new result is posted as the sequencer returns to idle
    `ASSERT_NOW(a_result_idle, clk, rst_n, $rose(m_axis_tvalid), s_axis_tready)

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                 $stable(m_axis_tdata))

endmodule

bind ac_rms_with_offset_tracking ars_checker u_ars_checker (.*);
